// File: src/cssi_pkg.sv
// ----------------------------------------------------------------------------
// cssi_pkg
// Shared types and constants for the conveyor start/stop interlock.
// ----------------------------------------------------------------------------
`default_nettype none

package cssi_pkg;

    localparam int unsigned MS_W       = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [MS_W-1:0] START_HOLD_MS_RST = MS_W'(500);
    localparam logic [MS_W-1:0] LAMP_PULSE_MS_RST = MS_W'(200);
    localparam logic [MS_W-1:0] COUNT_MAX         = {MS_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_HOLD = 2'd0,
        CFG_LAMP_PULSE = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [MS_W-1:0] start_hold_ms;
        logic [MS_W-1:0] lamp_pulse_ms;
    } t_cfg;

    typedef struct packed {
        logic            start_button;
        logic            stop_contact;
        logic            part_sensor;
        logic [MS_W-1:0] scan_ms;
    } t_scan;

endpackage

`default_nettype wire

// File: src/cssi_cfg.sv
// ----------------------------------------------------------------------------
// cssi_cfg
// Configuration registers: start hold preset and lamp pulse length.
// ----------------------------------------------------------------------------
`default_nettype none

module cssi_cfg
    import cssi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_hold_ms <= START_HOLD_MS_RST;
            r_cfg.lamp_pulse_ms <= LAMP_PULSE_MS_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_START_HOLD: r_cfg.start_hold_ms <= i_cfg_data[MS_W-1:0];
                CFG_LAMP_PULSE: r_cfg.lamp_pulse_ms <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/cssi_in_stage.sv
// ----------------------------------------------------------------------------
// cssi_in_stage
// Input register for one scan item, with stall toward the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module cssi_in_stage
    import cssi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_scan i_scan,
    input  wire logic  i_free,
    output logic       o_valid,
    output t_scan      o_scan
);

    logic  r_valid;
    logic  n_valid;
    t_scan r_scan;
    logic  load;

    assign o_stall = r_valid && !i_free;
    assign load    = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_scan <= i_scan;
        end
    end

    assign o_valid = r_valid;
    assign o_scan  = r_scan;

endmodule

`default_nettype wire

// File: src/cssi_core.sv
// ----------------------------------------------------------------------------
// cssi_core
// Timer, motor latch, lamp pulse and part counter; state doubles as result.
// ----------------------------------------------------------------------------
`default_nettype none

module cssi_core
    import cssi_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_valid,
    input  wire t_scan            i_scan,
    output logic                  o_free,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_motor_on,
    output logic                  o_lamp_on,
    output logic [MS_W-1:0]       o_parts_total
);

    logic            r_out_valid;
    logic [MS_W-1:0] r_hold_elapsed;
    logic            r_hold_done_prev;
    logic            r_motor_latch;
    logic            r_sensor_prev;
    logic            r_pulse_active;
    logic [MS_W-1:0] r_pulse_elapsed;
    logic            r_edge_prev;
    logic [MS_W-1:0] r_count;

    logic [MS_W-1:0] n_hold_elapsed;
    logic            n_hold_done;
    logic            n_motor_latch;
    logic            n_pulse_active;
    logic [MS_W-1:0] n_pulse_elapsed;
    logic [MS_W-1:0] n_count;

    logic            take;
    logic            stop_hit;
    logic            sensor_rise;
    logic            cu_rise;
    logic [MS_W:0]   hold_sum;
    logic [MS_W:0]   pulse_sum;

    assign o_free      = !r_out_valid || !i_stall;
    assign take        = i_valid && o_free;
    assign stop_hit    = !i_scan.stop_contact;
    assign sensor_rise = i_scan.part_sensor && !r_sensor_prev;
    assign cu_rise     = sensor_rise && !r_edge_prev;
    assign hold_sum    = {1'b0, r_hold_elapsed} + {1'b0, i_scan.scan_ms};
    assign pulse_sum   = {1'b0, r_pulse_elapsed} + {1'b0, i_scan.scan_ms};

    always_comb begin
        n_hold_elapsed = r_hold_elapsed;
        n_hold_done    = 1'b0;
        if (i_scan.start_button) begin
            if (r_hold_elapsed < i_cfg.start_hold_ms) begin
                if (hold_sum > {1'b0, i_cfg.start_hold_ms}) begin
                    n_hold_elapsed = i_cfg.start_hold_ms;
                end else begin
                    n_hold_elapsed = hold_sum[MS_W-1:0];
                end
            end
            n_hold_done = n_hold_elapsed >= i_cfg.start_hold_ms;
        end else begin
            n_hold_elapsed = '0;
        end
    end

    assign n_motor_latch = !stop_hit
                           && ((n_hold_done && !r_hold_done_prev) || r_motor_latch);

    always_comb begin
        n_pulse_active  = r_pulse_active;
        n_pulse_elapsed = r_pulse_elapsed;
        if (r_pulse_active) begin
            if (pulse_sum >= {1'b0, i_cfg.lamp_pulse_ms}) begin
                n_pulse_elapsed = i_cfg.lamp_pulse_ms;
                n_pulse_active  = 1'b0;
            end else begin
                n_pulse_elapsed = pulse_sum[MS_W-1:0];
            end
        end else if (sensor_rise) begin
            n_pulse_active  = 1'b1;
            n_pulse_elapsed = '0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (stop_hit) begin
            n_count = '0;
        end else if (cu_rise && (r_count != COUNT_MAX)) begin
            n_count = r_count + MS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_hold_elapsed   <= '0;
            r_hold_done_prev <= 1'b0;
            r_motor_latch    <= 1'b0;
            r_sensor_prev    <= 1'b0;
            r_pulse_active   <= 1'b0;
            r_pulse_elapsed  <= '0;
            r_edge_prev      <= 1'b0;
            r_count          <= '0;
        end else begin
            if (o_free) begin
                r_out_valid <= i_valid;
            end
            if (take) begin
                r_hold_elapsed   <= n_hold_elapsed;
                r_hold_done_prev <= n_hold_done;
                r_motor_latch    <= n_motor_latch;
                r_sensor_prev    <= i_scan.part_sensor;
                r_pulse_active   <= n_pulse_active;
                r_pulse_elapsed  <= n_pulse_elapsed;
                r_edge_prev      <= sensor_rise;
                r_count          <= n_count;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_motor_on    = r_motor_latch;
    assign o_lamp_on     = r_pulse_active;
    assign o_parts_total = r_count;

endmodule

`default_nettype wire

// File: src/conveyor_start_stop_interlock.sv
// ----------------------------------------------------------------------------
// conveyor_start_stop_interlock
// Scan-driven start/stop interlock with part lamp pulse and part counter.
//
// Input channel: i_valid / o_stall carry one scan (start, stop contact,
// part sensor, ms since previous scan). Output channel: o_valid / i_stall
// carry one result per scan (motor drive, lamp, part count).
// A transfer happens on a rising edge with valid high and stall low.
// A scan accepted on the input goes to the input register, then to the
// state / result registers, which drive o_valid. Throughput: one scan per
// cycle while i_stall is low, set by the single registered pass from the
// input register through the state update into the state / result registers.
// Stall: while i_stall holds a result, one more scan waits in the input
// register; o_stall rises only when both registers are full and i_stall
// is high.
// Reset (i_rst_n low, synchronous): both channels empty, timers, latch,
// pulse and count cleared, start hold 500 ms, lamp pulse 200 ms.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 start hold, 1 lamp pulse); other indexes are ignored. Write only idle.
// ----------------------------------------------------------------------------
`default_nettype none

module conveyor_start_stop_interlock
    import cssi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_start_button,
    input  wire logic                  i_stop_contact,
    input  wire logic                  i_part_sensor,
    input  wire logic [MS_W-1:0]       i_scan_ms,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_motor_on,
    output logic                       o_lamp_on,
    output logic [MS_W-1:0]            o_parts_total
);

    t_cfg  cfg;
    t_scan scan_in;
    t_scan scan_q;
    logic  scan_q_valid;
    logic  core_free;

    assign scan_in.start_button = i_start_button;
    assign scan_in.stop_contact = i_stop_contact;
    assign scan_in.part_sensor  = i_part_sensor;
    assign scan_in.scan_ms      = i_scan_ms;

    cssi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cssi_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_scan  (scan_in),
        .i_free  (core_free),
        .o_valid (scan_q_valid),
        .o_scan  (scan_q)
    );

    cssi_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (scan_q_valid),
        .i_scan        (scan_q),
        .o_free        (core_free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_motor_on    (o_motor_on),
        .o_lamp_on     (o_lamp_on),
        .o_parts_total (o_parts_total)
    );

endmodule

`default_nettype wire

// File: src/cssi_checker.sv
// ----------------------------------------------------------------------------
// cssi_checker
// Port-level checks on the interlock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cssi_checker
    import cssi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  o_stall,
    input  wire logic                  o_valid,
    input  wire logic                  i_stall,
    input  wire logic                  o_motor_on,
    input  wire logic                  o_lamp_on,
    input  wire logic [MS_W-1:0]       o_parts_total
);

    logic            r_have_last;
    logic [MS_W-1:0] r_last_count;
    logic            out_xfer;

    assign out_xfer = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
        end else if (out_xfer) begin
            r_have_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer) begin
            r_last_count <= o_parts_total;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("channels not empty after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while result side can move");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_have_last |->
            o_parts_total == '0 || o_parts_total == r_last_count
            || o_parts_total == r_last_count + MS_W'(1))
        else $error("part count jumped between results");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_motor_on)
            && $stable(o_lamp_on) && $stable(o_parts_total))
        else $error("stalled result changed");

endmodule

bind conveyor_start_stop_interlock cssi_checker u_cssi_checker (.*);

`default_nettype wire
